// ===== hdl/rse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_pkg: shared types and constants of the RGB stencil edge marker
// Pixel and queue entry layouts, queue sizing, register indexes, reset sizes.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int CHAN_W   = 8;
    localparam int COORD_W  = 10;
    localparam int SIZE_W   = 11;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int RST_WIDTH      = 640;
    localparam int RST_HEIGHT     = 480;
    localparam int MIN_SIZE       = 3;

    localparam logic [CHAN_W-1:0] MARK_VALUE = 8'd254;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        pixel_t             value;
    } fifo_entry_t;

    typedef struct packed {
        logic [FIFO_CW-1:0] count;
        logic               empty;
    } fifo_status_t;

    typedef struct packed {
        logic stage_valid;
        logic push;
    } front_status_t;

    // 8*center minus six neighbors, modulo 256
    function automatic logic [CHAN_W-1:0] stencil_chan(
        input logic [CHAN_W-1:0] ctr,
        input logic [CHAN_W-1:0] up,
        input logic [CHAN_W-1:0] dn,
        input logic [CHAN_W-1:0] lf,
        input logic [CHAN_W-1:0] rt,
        input logic [CHAN_W-1:0] dr,
        input logic [CHAN_W-1:0] ul
    );
        logic [CHAN_W-1:0] ctr8;
        begin
            ctr8 = {ctr[CHAN_W-4:0], 3'b000};
            return ctr8 - up - dn - lf - rt - dr - ul;
        end
    endfunction

endpackage

// ===== hdl/rse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_front: position tracking, line store, window and stencil
// Accepts pixels, tracks row and column, reads the line store, shifts the
// 3x3 window and pushes filtered interior pixels into the queue.
// ----------------------------------------------------------------------------
module rse_front #(
    parameter int MAX_WIDTH  = rse_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rse_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rse_pkg::pixel_t                     in_px,
    input  logic                                frame_start,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      eff_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     eff_height,
    input  rse_pkg::fifo_status_t               fifo_st,
    output logic                                push,
    output rse_pkg::fifo_entry_t                push_entry,
    output rse_pkg::front_status_t              front_st
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int LW = 2 * $bits(rse_pkg::pixel_t);
    localparam int PW = $bits(rse_pkg::pixel_t);

    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic           a_valid_reg;
    logic [CW-1:0]  a_col_reg, a_col_cur;
    logic [RW-1:0]  a_row_reg, a_row_cur;
    rse_pkg::pixel_t a_px_reg;
    logic [LW-1:0]  line_mem [MAX_WIDTH];
    logic [LW-1:0]  mem_q_reg;
    rse_pkg::pixel_t win_reg [9];

    logic           accept;
    logic [CW-1:0]  c0;
    logic [HW-1:0]  r0, r1;
    logic [WW-1:0]  c_inc;
    logic [HW-1:0]  r_inc;
    rse_pkg::pixel_t top, mid;
    logic [LW-1:0]  wr_data;
    logic [rse_pkg::FIFO_CW:0] credit;
    logic [RW-1:0]  row_m1;
    logic [CW-1:0]  col_m1;

    // conservative credit: every item in flight may need a queue slot
    assign credit   = {1'b0, fifo_st.count} + {{rse_pkg::FIFO_CW{1'b0}}, a_valid_reg};
    assign in_ready = (credit < (rse_pkg::FIFO_CW+1)'(rse_pkg::FIFO_DEPTH));
    assign accept   = in_valid && in_ready;

    // position of the accepted pixel
    always_comb
    begin
        c0 = frame_start ? '0 : col_reg;
        r0 = frame_start ? '0 : HW'(row_reg);
        a_col_cur = c0;
        r1 = r0;
        if (WW'(c0) >= eff_width)
        begin
            a_col_cur = '0;
            r1 = r0 + 1'b1;
        end
        if (r1 >= eff_height)
        begin
            r1 = '0;
        end
        a_row_cur = RW'(r1);

        // position of the pixel after this one
        c_inc = WW'(a_col_cur) + 1'b1;
        r_inc = HW'(a_row_cur) + 1'b1;
        col_next = CW'(c_inc);
        row_next = a_row_cur;
        if (c_inc >= eff_width)
        begin
            col_next = '0;
            row_next = (r_inc >= eff_height) ? '0 : RW'(r_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_col_reg <= a_col_cur;
            a_row_reg <= a_row_cur;
            a_px_reg  <= in_px;
        end
    end

    // line store entry: low half two rows up, high half one row up
    assign top     = mem_q_reg[PW-1:0];
    assign mid     = mem_q_reg[LW-1:PW];
    assign wr_data = {a_px_reg, mid};

    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
        begin
            line_mem[a_col_reg] <= wr_data;
        end
        if (accept)
        begin
            // bypass a write to the same column in this cycle
            if (a_valid_reg && (a_col_reg == a_col_cur))
            begin
                mem_q_reg <= wr_data;
            end
            else
            begin
                mem_q_reg <= line_mem[a_col_cur];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (a_valid_reg)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= top;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= mid;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= a_px_reg;
        end
    end

    // stencil on the window as it stands after this shift
    assign row_m1 = a_row_reg - 1'b1;
    assign col_m1 = a_col_reg - 1'b1;
    assign push   = a_valid_reg && (HW'(a_row_reg) >= HW'(2)) && (WW'(a_col_reg) >= WW'(2));

    always_comb
    begin
        push_entry.row = rse_pkg::COORD_W'(row_m1);
        push_entry.col = rse_pkg::COORD_W'(col_m1);
        push_entry.value.blue = rse_pkg::stencil_chan(win_reg[5].blue, win_reg[2].blue,
            win_reg[8].blue, win_reg[4].blue, mid.blue, a_px_reg.blue, win_reg[1].blue);
        push_entry.value.green = rse_pkg::stencil_chan(win_reg[5].green, win_reg[2].green,
            win_reg[8].green, win_reg[4].green, mid.green, a_px_reg.green, win_reg[1].green);
        push_entry.value.red = rse_pkg::stencil_chan(win_reg[5].red, win_reg[2].red,
            win_reg[8].red, win_reg[4].red, mid.red, a_px_reg.red, win_reg[1].red);
    end

    assign front_st.stage_valid = a_valid_reg;
    assign front_st.push        = push;

endmodule

// ===== hdl/rse_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_fifo: short queue between front and back
// Holds filtered pixels so the front streams on during short output stalls.
// ----------------------------------------------------------------------------
module rse_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rse_pkg::fifo_entry_t  push_entry,
    input  logic                  pop,
    output rse_pkg::fifo_entry_t  head,
    output rse_pkg::fifo_status_t fifo_st
);

    rse_pkg::fifo_entry_t           slot_reg [rse_pkg::FIFO_DEPTH];
    logic [rse_pkg::FIFO_AW-1:0]    wr_ptr_reg;
    logic [rse_pkg::FIFO_AW-1:0]    rd_ptr_reg;
    logic [rse_pkg::FIFO_CW-1:0]    count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head          = slot_reg[rd_ptr_reg];
    assign fifo_st.count = count_reg;
    assign fifo_st.empty = (count_reg == '0);

endmodule

// ===== hdl/rse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_back: dominance check and output register
// Pops filtered pixels, applies the channel dominance mark, holds the result.
// ----------------------------------------------------------------------------
module rse_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rse_pkg::fifo_entry_t                 head,
    input  rse_pkg::fifo_status_t                fifo_st,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [rse_pkg::COORD_W-1:0]          out_row,
    output logic [rse_pkg::COORD_W-1:0]          out_col,
    output logic [rse_pkg::CHAN_W-1:0]           out_blue,
    output logic [rse_pkg::CHAN_W-1:0]           out_green,
    output logic [rse_pkg::CHAN_W-1:0]           out_red,
    output logic                                 dominance_mark
);

    logic                          valid_reg;
    rse_pkg::fifo_entry_t          data_reg;
    logic                          mark_reg;
    logic [rse_pkg::CHAN_W+1:0]    b9, g9, r9;
    logic                          mark;

    assign pop = !fifo_st.empty && (!valid_reg || out_ready);

    // two spare bits so the sum of two channels cannot wrap
    assign b9 = {2'b00, head.value.blue};
    assign g9 = {2'b00, head.value.green};
    assign r9 = {2'b00, head.value.red};
    assign mark = (r9 > g9 + b9) || (g9 > r9 + b9) || (b9 > g9 + r9);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg.row <= head.row;
            data_reg.col <= head.col;
            mark_reg     <= mark;
            if (mark)
            begin
                data_reg.value <= {rse_pkg::MARK_VALUE, rse_pkg::MARK_VALUE,
                                   rse_pkg::MARK_VALUE};
            end
            else
            begin
                data_reg.value <= head.value;
            end
        end
    end

    assign out_valid      = valid_reg;
    assign out_row        = data_reg.row;
    assign out_col        = data_reg.col;
    assign out_blue       = data_reg.value.blue;
    assign out_green      = data_reg.value.green;
    assign out_red        = data_reg.value.red;
    assign dominance_mark = mark_reg;

endmodule

// ===== hdl/rgb_stencil_edge_marker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_stencil_edge_marker: streaming 3x3 edge filter with dominance mark
// The pixel completing a window is registered in the window stage; its result
// is pushed into the queue and popped into the output register. Throughput:
// one pixel per clock while the queue has room, set by the one line store
// read-modify-write per pixel. Reset clears counters, window and queue and
// sets the sizes to 640 by 480; the line store is not cleared.
// ----------------------------------------------------------------------------
module rgb_stencil_edge_marker #(
    parameter int MAX_WIDTH  = rse_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rse_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rse_pkg::CHAN_W-1:0]        in_blue,
    input  logic [rse_pkg::CHAN_W-1:0]        in_green,
    input  logic [rse_pkg::CHAN_W-1:0]        in_red,
    input  logic                              frame_start,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rse_pkg::COORD_W-1:0]       out_row,
    output logic [rse_pkg::COORD_W-1:0]       out_col,
    output logic [rse_pkg::CHAN_W-1:0]        out_blue,
    output logic [rse_pkg::CHAN_W-1:0]        out_green,
    output logic [rse_pkg::CHAN_W-1:0]        out_red,
    output logic                              dominance_mark,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rse_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rse_pkg::SIZE_W-1:0]        cfg_data
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CWW = (WW > rse_pkg::SIZE_W) ? WW : rse_pkg::SIZE_W;
    localparam int CHW = (HW > rse_pkg::SIZE_W) ? HW : rse_pkg::SIZE_W;
    localparam int W_RST = (rse_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : rse_pkg::RST_WIDTH;
    localparam int H_RST = (rse_pkg::RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : rse_pkg::RST_HEIGHT;

    logic [WW-1:0]  eff_width_reg, eff_width_next;
    logic [HW-1:0]  eff_height_reg, eff_height_next;
    logic [CWW-1:0] wx;
    logic [CHW-1:0] hx;

    rse_pkg::pixel_t        in_px;
    logic                   push;
    logic                   pop;
    rse_pkg::fifo_entry_t   push_entry;
    rse_pkg::fifo_entry_t   head;
    rse_pkg::fifo_status_t  fifo_st;
    rse_pkg::front_status_t front_st;

    assign cfg_ready = 1'b1;

    // store sizes already clamped to the supported range
    always_comb
    begin
        wx = CWW'(cfg_data);
        hx = CHW'(cfg_data);
        if (wx < CWW'(rse_pkg::MIN_SIZE))
            eff_width_next = WW'(rse_pkg::MIN_SIZE);
        else if (wx > CWW'(MAX_WIDTH))
            eff_width_next = WW'(MAX_WIDTH);
        else
            eff_width_next = WW'(wx);
        if (hx < CHW'(rse_pkg::MIN_SIZE))
            eff_height_next = HW'(rse_pkg::MIN_SIZE);
        else if (hx > CHW'(MAX_HEIGHT))
            eff_height_next = HW'(MAX_HEIGHT);
        else
            eff_height_next = HW'(hx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_width_reg  <= WW'(W_RST);
            eff_height_reg <= HW'(H_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rse_pkg::REG_IMAGE_WIDTH:  eff_width_reg  <= eff_width_next;
                rse_pkg::REG_IMAGE_HEIGHT: eff_height_reg <= eff_height_next;
                default: ;
            endcase
        end
    end

    assign in_px.blue  = in_blue;
    assign in_px.green = in_green;
    assign in_px.red   = in_red;

    rse_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_px       (in_px),
        .frame_start (frame_start),
        .eff_width   (eff_width_reg),
        .eff_height  (eff_height_reg),
        .fifo_st     (fifo_st),
        .push        (push),
        .push_entry  (push_entry),
        .front_st    (front_st)
    );

    rse_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .fifo_st    (fifo_st)
    );

    rse_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .fifo_st        (fifo_st),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_row        (out_row),
        .out_col        (out_col),
        .out_blue       (out_blue),
        .out_green      (out_green),
        .out_red        (out_red),
        .dominance_mark (dominance_mark)
    );

    // every accepted transaction reaches the line store stage next cycle
    a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> front_st.stage_valid)
        else $error("accepted pixel did not reach the window stage");

    // credit check: queue never overflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        front_st.push |-> (fifo_st.count < rse_pkg::FIFO_CW'(rse_pkg::FIFO_DEPTH)))
        else $error("push into a full queue");

    // a marked transaction carries the mark value on all channels
    a_mark_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dominance_mark) |-> (out_blue == rse_pkg::MARK_VALUE
            && out_green == rse_pkg::MARK_VALUE && out_red == rse_pkg::MARK_VALUE))
        else $error("marked result without mark value");

endmodule

// ===== sim/rse_stencil_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_stencil_checker: result predictor and scoreboard for the edge marker
// Follows register writes and accepted pixels with its own line store and
// window, queues the filtered result each pixel should produce and compares
// every accepted result with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module rse_stencil_checker
    import rse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [CHAN_W-1:0]    in_blue,
    input  logic [CHAN_W-1:0]    in_green,
    input  logic [CHAN_W-1:0]    in_red,
    input  logic                 frame_start,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [COORD_W-1:0]   out_row,
    input  logic [COORD_W-1:0]   out_col,
    input  logic [CHAN_W-1:0]    out_blue,
    input  logic [CHAN_W-1:0]    out_green,
    input  logic [CHAN_W-1:0]    out_red,
    input  logic                 dominance_mark,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   due_count
);

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        pixel_t             value;
        logic               mark;
    } filtered_t;

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    pixel_t            row_above  [DEF_MAX_WIDTH];
    pixel_t            row_above2 [DEF_MAX_WIDTH];
    pixel_t            win [9];
    int                row_cnt;
    int                col_cnt;
    filtered_t         filtered_due [$];

    function automatic int clamp_dim(input int v, input int lim);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic int chan_of(input pixel_t p, input int k);
        case (k)
            0:       return p.blue;
            1:       return p.green;
            default: return p.red;
        endcase
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Advance the position, roll the line store and window, queue a result
    // once the window is centered on an interior pixel.
    task automatic run_stencil(input pixel_t px, input logic fs);
        int        w_eff;
        int        h_eff;
        int        r;
        int        c;
        int        acc;
        int        v [3];
        logic      mark;
        pixel_t    top_px;
        pixel_t    mid_px;
        filtered_t res;
        w_eff = clamp_dim(width_reg, DEF_MAX_WIDTH);
        h_eff = clamp_dim(height_reg, DEF_MAX_HEIGHT);
        if (fs)
        begin
            row_cnt = 0;
            col_cnt = 0;
        end
        if (col_cnt >= w_eff)
        begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h_eff)
            row_cnt = 0;
        r = row_cnt;
        c = col_cnt;

        top_px        = row_above2[c];
        mid_px        = row_above[c];
        row_above2[c] = mid_px;
        row_above[c]  = px;

        win[0] = win[1]; win[1] = win[2]; win[2] = top_px;
        win[3] = win[4]; win[4] = win[5]; win[5] = mid_px;
        win[6] = win[7]; win[7] = win[8]; win[8] = px;

        if (r >= 2 && c >= 2)
        begin
            for (int k = 0; k < 3; k++)
            begin
                acc = 8 * chan_of(win[4], k)
                    - chan_of(win[1], k) - chan_of(win[7], k)
                    - chan_of(win[3], k) - chan_of(win[5], k)
                    - chan_of(win[8], k) - chan_of(win[0], k);
                v[k] = acc & 255;
            end
            mark = (v[2] > v[1] + v[0]) || (v[1] > v[2] + v[0]) || (v[0] > v[1] + v[2]);
            res.row  = COORD_W'(r - 1);
            res.col  = COORD_W'(c - 1);
            res.mark = mark;
            if (mark)
                res.value = {MARK_VALUE, MARK_VALUE, MARK_VALUE};
            else
                res.value = {CHAN_W'(v[2]), CHAN_W'(v[1]), CHAN_W'(v[0])};
            filtered_due.push_back(res);
        end

        col_cnt = c + 1;
        if (col_cnt >= w_eff)
        begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= h_eff)
                row_cnt = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        filtered_t want;
        if (!rst_n)
        begin
            width_reg  = SIZE_W'(RST_WIDTH);
            height_reg = SIZE_W'(RST_HEIGHT);
            for (int i = 0; i < DEF_MAX_WIDTH; i++)
            begin
                row_above[i]  = '0;
                row_above2[i] = '0;
            end
            for (int i = 0; i < 9; i++)
                win[i] = '0;
            row_cnt = 0;
            col_cnt = 0;
            filtered_due.delete();
            fail_count = 0;
            due_count  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (in_valid && in_ready)
                run_stencil({in_red, in_green, in_blue}, frame_start);
            if (out_valid && out_ready)
            begin
                if (filtered_due.size() == 0)
                begin
                    $error("result at row %0d col %0d with no expectation waiting",
                           out_row, out_col);
                    fail_count++;
                end
                else
                begin
                    want = filtered_due.pop_front();
                    check_field("out_row", want.row, out_row);
                    check_field("out_col", want.col, out_col);
                    check_field("out_blue", want.value.blue, out_blue);
                    check_field("out_green", want.value.green, out_green);
                    check_field("out_red", want.value.red, out_red);
                    check_field("dominance_mark", want.mark, dominance_mark);
                end
            end
            due_count = filtered_due.size();
        end
    end

endmodule

// ===== sim/rgb_stencil_edge_marker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_stencil_edge_marker_tb: stimulus and verdict for the edge marker
// Streams RGB frames of many geometries through the filter with random gaps
// on the pixel side and random stalls on the result side; size registers are
// rewritten between phases while the block is drained. Prediction and
// comparison live in rse_stencil_checker.
// ----------------------------------------------------------------------------
module rgb_stencil_edge_marker_tb;
    import rse_pkg::*;

    localparam int LATENCY_WAIT = 6;
    localparam int RANDOM_PIXELS = 1700;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CHAN_W-1:0]    in_blue;
    logic [CHAN_W-1:0]    in_green;
    logic [CHAN_W-1:0]    in_red;
    logic                 frame_start;
    logic                 out_valid;
    logic                 out_ready;
    logic [COORD_W-1:0]   out_row;
    logic [COORD_W-1:0]   out_col;
    logic [CHAN_W-1:0]    out_blue;
    logic [CHAN_W-1:0]    out_green;
    logic [CHAN_W-1:0]    out_red;
    logic                 dominance_mark;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;
    int                   fails;
    int                   due;

    bit steady;
    int px_sent;

    // red/green/blue; center of the first interior pixel is pure red
    pixel_t probe_px [12] = '{
        24'h000000, 24'hFFFFFF, 24'h000000,
        24'h000000, 24'hFF0000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF
    };

    rgb_stencil_edge_marker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_blue        (in_blue),
        .in_green       (in_green),
        .in_red         (in_red),
        .frame_start    (frame_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_row        (out_row),
        .out_col        (out_col),
        .out_blue       (out_blue),
        .out_green      (out_green),
        .out_red        (out_red),
        .dominance_mark (dominance_mark),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    rse_stencil_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_blue        (in_blue),
        .in_green       (in_green),
        .in_red         (in_red),
        .frame_start    (frame_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_row        (out_row),
        .out_col        (out_col),
        .out_blue       (out_blue),
        .out_green      (out_green),
        .out_red        (out_red),
        .dominance_mark (dominance_mark),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fails),
        .due_count      (due)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(13, 0);
    endfunction

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(9, 0))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return CHAN_W'($urandom_range(15, 0));
            default: return CHAN_W'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so a back-to-back pixel keeps it asserted.
    task automatic push_pixel(input pixel_t px, input logic fs);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        in_red      <= px.red;
        in_green    <= px.green;
        in_blue     <= px.blue;
        frame_start <= fs;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        px_sent++;
    endtask

    task automatic send_frame(input int count, input bit fs_first, input bit noisy);
        logic fs;
        for (int i = 0; i < count; i++)
        begin
            if (i == 0)
                fs = fs_first;
            else
                fs = noisy && ($urandom_range(299, 0) == 0);
            push_pixel(rand_pixel(), fs);
        end
    endtask

    // Hold off pixels until every queued result is out, then let the
    // pipeline empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (due != 0)
            @(negedge clk);
        repeat (LATENCY_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= SIZE_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : sink
        int stall;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int w;
        int h;
        int len;
        int frames;
        int base;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_blue     = '0;
        in_green    = '0;
        in_red      = '0;
        frame_start = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_IMAGE_WIDTH;
        cfg_data    = '0;
        steady      = 1'b0;
        px_sent     = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // reset geometry: too few pixels to reach an interior one
        send_frame(5, 1'b1, 1'b0);

        // smallest frame with two interior pixels
        write_reg(REG_IMAGE_WIDTH, MIN_SIZE);
        write_reg(REG_IMAGE_HEIGHT, 4);
        for (int i = 0; i < 12; i++)
            push_pixel(probe_px[i], i == 0);
        // run past the last row without restart, then restart mid-row
        send_frame(4, 1'b0, 1'b0);
        send_frame(4, 1'b1, 1'b0);

        // sizes below the minimum clamp to 3x3
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 2);
        send_frame(9, 1'b1, 1'b0);

        // shrink the width mid-frame: the next pixel moves to the next row
        write_reg(REG_IMAGE_WIDTH, 8);
        write_reg(REG_IMAGE_HEIGHT, 6);
        send_frame(29, 1'b1, 1'b0);
        write_reg(REG_IMAGE_WIDTH, 4);
        send_frame(14, 1'b0, 1'b0);

        // exact maximum sizes, short burst only
        write_reg(REG_IMAGE_WIDTH, DEF_MAX_WIDTH);
        write_reg(REG_IMAGE_HEIGHT, DEF_MAX_HEIGHT);
        send_frame(12, 1'b1, 1'b1);

        base = px_sent;
        while (px_sent < base + RANDOM_PIXELS)
        begin
            steady = ($urandom_range(3, 0) == 0);
            if ($urandom_range(15, 0) == 0)
            begin
                // odd register value, short burst
                case ($urandom_range(4, 0))
                    0:       len = 0;
                    1:       len = 1;
                    2:       len = DEF_MAX_WIDTH;
                    3:       len = 2047;
                    default: len = $urandom_range(2047, 0);
                endcase
                write_reg(($urandom_range(1, 0) == 0) ? REG_IMAGE_WIDTH : REG_IMAGE_HEIGHT,
                          len);
                send_frame($urandom_range(30, 5), 1'b1, 1'b1);
            end
            else
            begin
                if ($urandom_range(7, 0) == 0)
                    w = $urandom_range(40, 3);
                else
                    w = $urandom_range(10, 3);
                h = $urandom_range(7, 3);
                write_reg(REG_IMAGE_WIDTH, w);
                write_reg(REG_IMAGE_HEIGHT, h);
                frames = $urandom_range(3, 1);
                for (int f = 0; f < frames; f++)
                begin
                    len = w * h;
                    case ($urandom_range(6, 0))
                        0:       len = $urandom_range(len - 1, 1);
                        1:       len = len + $urandom_range(2 * w, 1);
                        default: len = len;
                    endcase
                    // width is unchanged within a phase, so later frames may
                    // continue without a restart
                    send_frame(len, (f == 0) || ($urandom_range(3, 0) != 0), 1'b1);
                    if ($urandom_range(9, 0) == 0)
                        settle();
                end
            end
        end

        steady = 1'b0;
        settle();
        if (fails == 0 && due == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
